FILE: sv/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

    // Capacity and time width of the task set
    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;

    // Fixed port field widths
    localparam int IN_FIELD_BITS  = 16;
    localparam int OUT_TIME_BITS  = 24;
    localparam int OUT_INDEX_BITS = 6;

    // Derived widths
    localparam int IDX_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
    localparam int DUE_BITS  = TIME_BITS + 1;
    // latest finish <= max arrival + sum of bursts < (MAX_TASKS + 1) * 2^TIME_BITS
    localparam int TICK_BITS = (TIME_BITS + CNT_BITS + 1 > OUT_TIME_BITS) ?
                               (TIME_BITS + CNT_BITS + 1) : OUT_TIME_BITS;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [IN_FIELD_BITS-1:0] arrival_time;
        logic [IN_FIELD_BITS-1:0] burst_time;
        logic                     last_task;
    } t_in_item;

    typedef struct packed {
        logic [OUT_INDEX_BITS-1:0] task_index;
        logic [OUT_TIME_BITS-1:0]  completion_time;
        logic [OUT_TIME_BITS-1:0]  turnaround_time;
        logic [OUT_TIME_BITS-1:0]  waiting_time;
        logic                      last_result;
    } t_out_item;

    // Classified task as it travels from front to back
    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [DUE_BITS-1:0]  due;     // arrival + burst
        logic                 last;
    } t_task;

endpackage

FILE: sv/srtf_front.sv
`timescale 1ns / 1ps

module srtf_front (
    input  srtf_pkg::t_in_item i_item,
    output srtf_pkg::t_task    o_task
);
    import srtf_pkg::*;

    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst_raw;
    logic [TIME_BITS-1:0] burst;

    always_comb begin
        arrival   = TIME_BITS'(i_item.arrival_time);
        burst_raw = TIME_BITS'(i_item.burst_time);
        // zero burst is served as one tick
        burst     = (burst_raw == '0) ? TIME_BITS'(1) : burst_raw;

        o_task.arrival = arrival;
        o_task.burst   = burst;
        o_task.due     = DUE_BITS'(arrival) + DUE_BITS'(burst);
        o_task.last    = i_item.last_task;
    end

endmodule

FILE: sv/srtf_queue.sv
`timescale 1ns / 1ps

module srtf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  srtf_pkg::t_task i_push,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output srtf_pkg::t_task o_pop
);
    import srtf_pkg::*;

    t_task                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/srtf_back.sv
`timescale 1ns / 1ps

module srtf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_task_valid,
    output logic                o_task_ready,
    input  srtf_pkg::t_task     i_task,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srtf_pkg::t_out_item o_out_data
);
    import srtf_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_GAP   = 5'b00100,
        S_APPLY = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;

    // task stores
    logic [TIME_BITS-1:0]     r_arr [MAX_TASKS];
    logic [DUE_BITS-1:0]      r_due [MAX_TASKS];
    logic [TIME_BITS-1:0]     r_rem [MAX_TASKS];
    logic [OUT_TIME_BITS-1:0] r_fin [MAX_TASKS];
    logic [MAX_TASKS-1:0]     r_finished;

    logic [CNT_BITS-1:0]  r_task_cnt;
    logic [CNT_BITS-1:0]  r_done_cnt;
    logic [TICK_BITS-1:0] r_tick;
    logic [CNT_BITS-1:0]  r_idx;

    // scan results
    logic [IDX_BITS-1:0]  r_pick;
    logic [TIME_BITS-1:0] r_best;
    logic                 r_found;
    logic [TIME_BITS-1:0] r_next;
    logic                 r_have_next;
    logic [TICK_BITS-1:0] r_gap;

    logic      r_out_valid;
    t_out_item r_out;

    logic [IDX_BITS-1:0]      idx;
    logic [IDX_BITS-1:0]      slot;
    logic [TIME_BITS-1:0]     rd_arr;
    logic [TIME_BITS-1:0]     rd_rem;
    logic [DUE_BITS-1:0]      rd_due;
    logic [OUT_TIME_BITS-1:0] rd_fin;
    logic                     rd_done;
    logic                     arrived;
    logic                     scan_last;
    logic                     run_split;
    logic [TICK_BITS-1:0]     run;
    logic [TICK_BITS-1:0]     tick_after;
    logic                     emit_go;

    always_comb begin
        idx        = r_idx[IDX_BITS-1:0];
        slot       = r_task_cnt[IDX_BITS-1:0];
        rd_arr     = r_arr[idx];
        rd_rem     = r_rem[idx];
        rd_due     = r_due[idx];
        rd_fin     = r_fin[idx];
        rd_done    = r_finished[idx];
        arrived    = (TICK_BITS'(rd_arr) <= r_tick);
        scan_last  = ((r_idx + CNT_BITS'(1)) == r_task_cnt);
        // serve the pick up to the next arrival or to its end
        run_split  = r_have_next && (r_gap < TICK_BITS'(r_best));
        run        = run_split ? r_gap : TICK_BITS'(r_best);
        tick_after = r_tick + run;
        emit_go    = !r_out_valid || i_out_ready;
    end

    assign o_task_ready = (r_state == S_LOAD);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // payload stores
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && i_task_valid && r_task_cnt < CNT_BITS'(MAX_TASKS)) begin
            r_arr[slot] <= i_task.arrival;
            r_due[slot] <= i_task.due;
        end
        if (r_state == S_LOAD && i_task_valid && r_task_cnt < CNT_BITS'(MAX_TASKS)) begin
            r_rem[slot] <= i_task.burst;
        end else if (r_state == S_APPLY) begin
            r_rem[r_pick] <= run_split ? (r_best - TIME_BITS'(r_gap)) : '0;
        end
        if (r_state == S_APPLY && !run_split) begin
            r_fin[r_pick] <= OUT_TIME_BITS'(tick_after);
        end
        if (r_state == S_SCAN && !rd_done) begin
            if (arrived) begin
                if (!r_found || rd_rem < r_best) begin
                    r_pick <= idx;
                    r_best <= rd_rem;
                end
            end else if (!r_have_next || rd_arr < r_next) begin
                r_next <= rd_arr;
            end
        end
        if (r_state == S_GAP) begin
            r_gap <= TICK_BITS'(r_next) - r_tick;
        end
        if (r_state == S_EMIT && emit_go) begin
            r_out.task_index      <= OUT_INDEX_BITS'(r_idx);
            r_out.completion_time <= rd_fin;
            r_out.turnaround_time <= rd_fin - OUT_TIME_BITS'(rd_arr);
            r_out.waiting_time    <= rd_fin - OUT_TIME_BITS'(rd_due);
            r_out.last_result     <= scan_last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_finished  <= '0;
            r_task_cnt  <= '0;
            r_done_cnt  <= '0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_have_next <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_task_valid) begin
                        if (r_task_cnt < CNT_BITS'(MAX_TASKS)) begin
                            r_finished[slot] <= 1'b0;
                            r_task_cnt       <= r_task_cnt + 1'b1;
                        end
                        if (i_task.last) begin
                            r_state     <= S_SCAN;
                            r_idx       <= '0;
                            r_found     <= 1'b0;
                            r_have_next <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    if (!rd_done) begin
                        if (arrived) begin
                            r_found <= 1'b1;
                        end else begin
                            r_have_next <= 1'b1;
                        end
                    end
                    if (scan_last) begin
                        r_state <= S_GAP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_GAP: begin
                    if (!r_found) begin
                        // idle: jump to the next arrival and rescan
                        r_tick      <= TICK_BITS'(r_next);
                        r_state     <= S_SCAN;
                        r_idx       <= '0;
                        r_have_next <= 1'b0;
                    end else begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_tick      <= tick_after;
                    r_idx       <= '0;
                    r_found     <= 1'b0;
                    r_have_next <= 1'b0;
                    if (!run_split) begin
                        r_finished[r_pick] <= 1'b1;
                        r_done_cnt         <= r_done_cnt + 1'b1;
                    end
                    // last completion moves on to the results
                    if (!run_split && (r_done_cnt + CNT_BITS'(1)) == r_task_cnt) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (scan_last) begin
                            r_finished <= '0;
                            r_task_cnt <= '0;
                            r_done_cnt <= '0;
                            r_tick     <= '0;
                            r_idx      <= '0;
                            r_state    <= S_LOAD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_task_cnt))
        else $error("scan index beyond task count");

    a_sim_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_GAP || r_state == S_APPLY)
            |-> (r_done_cnt < r_task_cnt))
        else $error("simulation running with all tasks finished");

    a_apply_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> r_found)
        else $error("service step without a ready task");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && emit_go && scan_last)
            |=> (r_state == S_LOAD && r_task_cnt == '0 && r_finished == '0))
        else $error("task set not cleared after final result");

endmodule

FILE: sv/srtf_schedule_simulator.sv
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time-first schedule simulator. Tasks arrive one
// beat per cycle while o_in_ready is high, as (arrival, burst), and are held in
// load order, up to MAX_TASKS; extra tasks are dropped and a zero burst counts
// as one. The beat with last_task set closes the set and starts the simulation
// from tick zero; when every task is done, one result beat per task comes out
// in index order with completion, turnaround and waiting times, last_result on
// the final one, and the block is clear for the next set. The simulation walks
// the task stores through their single read port, one task per cycle; each
// scheduling step is a scan over all n tasks, then S_GAP and, except on an
// idle jump, S_APPLY. A set needs at most about 3n steps (completions,
// preemptions at arrivals and idle jumps), then one result per cycle comes
// out when the output side keeps up. Intake stays open during the run until
// the two-entry queue in front of the simulator is full.
module srtf_schedule_simulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srtf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srtf_pkg::t_out_item o_out_data
);
    import srtf_pkg::*;

    t_task front_task;   // classified task from the front end
    t_task q_task;       // head of the queue
    logic  q_valid;
    logic  q_ready;

    // front: mask times, repair zero bursts, precompute arrival + burst
    srtf_front u_front (
        .i_item (i_in_data),
        .o_task (front_task)
    );

    // decouples intake from the simulator
    srtf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push       (front_task),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop        (q_task)
    );

    // back: task stores, scheduling engine and result register
    srtf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (q_valid),
        .o_task_ready (q_ready),
        .i_task       (q_task),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
